[rtl/efd_pkg.sv]
// ---------------------------------------------------------------------------
// efd_pkg - shared definitions for the escaped frame deframer
// Sizes, register indexes, reset values and the structs passed between
// the front parser, the descriptor queue and the back emitter.
// ---------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

  // Frame capacity and derived widths
  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  // Count must hold MAX_FRAME + 1 for the overflow check
  localparam int CNT_W     = $clog2(MAX_FRAME + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

  // Two banks of frame storage, one per queued frame
  localparam int NUM_BANKS = 2;
  localparam int RAM_DEPTH = NUM_BANKS * MAX_FRAME;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int Q_DEPTH   = NUM_BANKS;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ESCAPE  = 3'd0,
    REG_START   = 3'd1,
    REG_STOP    = 3'd2,
    REG_MIN_LEN = 3'd3,
    REG_MAX_LEN = 3'd4
  } reg_idx_e;

  // Reset values of the registers
  localparam logic [7:0] ESCAPE_RST  = 8'd27;
  localparam logic [7:0] START_RST   = 8'd83;
  localparam logic [7:0] STOP_RST    = 8'd80;
  localparam logic [6:0] MIN_LEN_RST = 7'd3;
  localparam logic [6:0] MAX_LEN_RST = 7'd64;

  // Fixed frame format values
  localparam logic [7:0] VERSION_0   = 8'd0;
  localparam logic [CNT_W-1:0] MIN_ACCEPT_CNT = CNT_W'(2);

  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [6:0] min_length;
    logic [6:0] max_length;
  } cfg_t;

  // Accepted frame: which bank and how many bytes
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_req_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    desc_t head;
  } q_status_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

[rtl/efd_if.sv]
// ---------------------------------------------------------------------------
// efd_if - handshake channels of the escaped frame deframer
// Received byte stream, decoded frame stream and register write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface efd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface efd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efd_pkg::CFG_IDX_W-1:0] index;
  logic [efd_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/efd_ram.sv]
// ---------------------------------------------------------------------------
// efd_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/efd_front.sv]
// ---------------------------------------------------------------------------
// efd_front - escape decoder and frame checker
// Decodes escapes, checks version, length and limits, writes frame bytes
// into the current bank and queues a descriptor for each accepted frame.
// ---------------------------------------------------------------------------
`default_nettype none

module efd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire efd_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  output logic                    in_ready_o,
  input  wire efd_pkg::q_status_t q_status_i,
  output efd_pkg::desc_req_t      push_o,
  output efd_pkg::wr_req_t        wr_o
);

  localparam int CW = efd_pkg::CNT_W;

  logic          esc_q, esc_d;
  logic          open_q, open_d;
  logic [7:0]    len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    sum_q, sum_d;
  logic          bank_q, bank_d;

  logic          fire;
  logic          add;
  logic          close_ok;
  logic [7:0]    len_new;
  logic [CW-1:0] cnt_new;
  logic [7:0]    cnt_new8;
  logic [7:0]    limit;
  logic          add_drop;

  // No bank free while two frames wait for the back end
  assign in_ready_o = !q_status_i.full;
  assign fire       = in_valid_i && in_ready_o;

  // Byte checks for an added byte
  always_comb begin
    len_new  = (cnt_q == CW'(1)) ? in_byte_i : len_q;
    cnt_new  = cnt_q + CW'(1);
    cnt_new8 = 8'(cnt_new);
    limit    = (8'(cfg_i.max_length) > 8'(efd_pkg::MAX_FRAME)) ?
               8'(efd_pkg::MAX_FRAME) : 8'(cfg_i.max_length);
    add_drop = ((cnt_q == '0) && (in_byte_i != efd_pkg::VERSION_0)) ||
               ((cnt_q == CW'(1)) && (in_byte_i < 8'(cfg_i.min_length))) ||
               (cnt_new8 > limit) ||
               ((len_new != 8'd0) && (cnt_new8 > len_new));
  end

  // Close check: enough bytes, count matches length byte, zero sum
  assign close_ok = open_q && (cnt_q > efd_pkg::MIN_ACCEPT_CNT) &&
                    (cnt_q <= efd_pkg::MAX_CNT) && (8'(cnt_q) == len_q) &&
                    (sum_q == 8'd0);

  // Next state of the parser
  always_comb begin
    esc_d  = esc_q;
    open_d = open_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    add    = 1'b0;
    push_o = '0;
    if (fire) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (in_byte_i == cfg_i.start_code) begin
          open_d = 1'b1;
          len_d  = '0;
          cnt_d  = '0;
          sum_d  = '0;
        end else if (in_byte_i == cfg_i.stop_code) begin
          push_o.valid = close_ok;
          open_d = 1'b0;
          len_d  = '0;
          cnt_d  = '0;
          sum_d  = '0;
        end else if (in_byte_i == cfg_i.escape_code) begin
          add = 1'b1;
        end else begin
          open_d = 1'b0;
          len_d  = '0;
          cnt_d  = '0;
          sum_d  = '0;
        end
      end else if (in_byte_i == cfg_i.escape_code) begin
        esc_d = 1'b1;
      end else begin
        add = 1'b1;
      end
      if (add && open_q) begin
        if (add_drop) begin
          esc_d  = 1'b0;
          open_d = 1'b0;
          len_d  = '0;
          cnt_d  = '0;
          sum_d  = '0;
        end else begin
          len_d = len_new;
          cnt_d = cnt_new;
          sum_d = sum_q + in_byte_i;
        end
      end
      if (push_o.valid) begin
        bank_d = ~bank_q;
      end
    end
    push_o.desc.bank = bank_q;
    push_o.desc.len  = cnt_q;
  end

  // Store write; a byte of a frame dropped here is never read
  always_comb begin
    wr_o.we   = fire && add && open_q && (cnt_q < efd_pkg::MAX_CNT);
    wr_o.addr = {bank_q, cnt_q[efd_pkg::ADDR_W-1:0]};
    wr_o.data = in_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      open_q <= 1'b0;
      len_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      esc_q  <= esc_d;
      open_q <= open_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
    end
  end

endmodule

`default_nettype wire

[rtl/efd_queue.sv]
// ---------------------------------------------------------------------------
// efd_queue - descriptor queue between front and back
// Two-entry FIFO of accepted frame descriptors, one per storage bank.
// ---------------------------------------------------------------------------
`default_nettype none

module efd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire efd_pkg::desc_req_t push_i,
  input  wire logic               pop_i,
  output efd_pkg::q_status_t      status_o
);

  localparam int PW = efd_pkg::Q_PTR_W;
  localparam int NW = efd_pkg::Q_CNT_W;

  efd_pkg::desc_t entry_q [efd_pkg::Q_DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [NW-1:0]  num_q;

  always_comb begin
    status_o.valid = (num_q != '0);
    status_o.full  = (num_q == NW'(efd_pkg::Q_DEPTH));
    status_o.head  = entry_q[rptr_q];
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wptr_q] <= push_i.desc;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= (wptr_q == PW'(efd_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(efd_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      case ({push_i.valid, pop_i})
        2'b10:   num_q <= num_q + NW'(1);
        2'b01:   num_q <= num_q - NW'(1);
        default: num_q <= num_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/efd_back.sv]
// ---------------------------------------------------------------------------
// efd_back - frame emitter
// Reads queued frames from the store one byte a cycle while buffer space
// is free; delivers them through a two-entry output buffer with a last mark.
// ---------------------------------------------------------------------------
`default_nettype none

module efd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire efd_pkg::q_status_t q_status_i,
  output logic                    pop_o,
  output efd_pkg::rd_req_t        rd_o,
  input  wire logic [7:0]         rd_data_i,
  efd_frame_if.source             frame_o
);

  localparam int CW = efd_pkg::CNT_W;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } obuf_t;

  logic [CW-1:0] idx_q;
  logic          inflight_q;
  logic          inflight_last_q;
  obuf_t         obuf_q [2];
  logic          owptr_q, orptr_q;
  logic [1:0]    occ_q;

  logic          out_pop;
  logic [1:0]    used;
  logic          issue;
  logic          is_last;

  assign out_pop = frame_o.valid && frame_o.ready;
  // Slots taken or promised by a read in flight
  assign used    = occ_q + {1'b0, inflight_q};
  assign issue   = q_status_i.valid && ((used < 2'd2) || out_pop);
  assign is_last = ((idx_q + CW'(1)) == q_status_i.head.len);
  assign pop_o   = issue && is_last;

  always_comb begin
    rd_o.re   = issue;
    rd_o.addr = {q_status_i.head.bank, idx_q[efd_pkg::ADDR_W-1:0]};
  end

  assign frame_o.valid      = (occ_q != 2'd0);
  assign frame_o.frame_byte = obuf_q[orptr_q].data;
  assign frame_o.frame_last = obuf_q[orptr_q].last;

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (inflight_q) begin
      obuf_q[owptr_q] <= '{data: rd_data_i, last: inflight_last_q};
    end
  end

  // Read sequencing and buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q           <= '0;
      inflight_q      <= 1'b0;
      inflight_last_q <= 1'b0;
      owptr_q         <= 1'b0;
      orptr_q         <= 1'b0;
      occ_q           <= 2'd0;
    end else begin
      inflight_q      <= issue;
      inflight_last_q <= is_last;
      if (issue) begin
        idx_q <= is_last ? '0 : idx_q + CW'(1);
      end
      if (inflight_q) begin
        owptr_q <= ~owptr_q;
      end
      if (out_pop) begin
        orptr_q <= ~orptr_q;
      end
      case ({inflight_q, out_pop})
        2'b10:   occ_q <= occ_q + 2'd1;
        2'b01:   occ_q <= occ_q - 2'd1;
        default: occ_q <= occ_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/escaped_frame_deframer_top.sv]
// ---------------------------------------------------------------------------
// escaped_frame_deframer_top - byte-stuffed frame decoder with checksum
//
// rx_i carries one received byte per request. ESC START opens a frame,
// ESC STOP closes it, ESC ESC is a literal escape, any other escape drops
// the frame. A frame that passes the version, length and zero-sum checks
// is sent on frame_o one byte per request, frame_last on the final byte.
// cfg_i writes the escape, start and stop codes and the length limits;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce.
// Input: one byte per cycle while rx_i.ready is high. The store has two
// banks; rx_i.ready drops only while two accepted frames both wait to be
// sent. Output: a frame is queued, read and buffered, then sent one byte
// per cycle while frame_o is ready, set by the store's single read port.
// A stall on frame_o holds the output buffer; the front keeps taking
// bytes until both banks are full.
// Reset clears parser, queue and buffer and loads register defaults;
// no clearing pass, the store is read only where written.
// ---------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  efd_rx_if.sink      rx_i,
  efd_cfg_if.sink     cfg_i,
  efd_frame_if.source frame_o
);

  efd_pkg::cfg_t      cfg_q;
  efd_pkg::q_status_t q_status;
  efd_pkg::desc_req_t push;
  efd_pkg::wr_req_t   wr;
  efd_pkg::rd_req_t   rd;
  logic               pop;
  logic [7:0]         rd_data;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_code <= efd_pkg::ESCAPE_RST;
      cfg_q.start_code  <= efd_pkg::START_RST;
      cfg_q.stop_code   <= efd_pkg::STOP_RST;
      cfg_q.min_length  <= efd_pkg::MIN_LEN_RST;
      cfg_q.max_length  <= efd_pkg::MAX_LEN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        efd_pkg::REG_ESCAPE:  cfg_q.escape_code <= cfg_i.data;
        efd_pkg::REG_START:   cfg_q.start_code  <= cfg_i.data;
        efd_pkg::REG_STOP:    cfg_q.stop_code   <= cfg_i.data;
        efd_pkg::REG_MIN_LEN: cfg_q.min_length  <= cfg_i.data[6:0];
        efd_pkg::REG_MAX_LEN: cfg_q.max_length  <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  efd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .q_status_i (q_status),
    .push_o     (push),
    .wr_o       (wr)
  );

  efd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (q_status)
  );

  efd_ram #(
    .WIDTH (8),
    .DEPTH (efd_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (rd_data)
  );

  efd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .pop_o      (pop),
    .rd_o       (rd),
    .rd_data_i  (rd_data),
    .frame_o    (frame_o)
  );

endmodule

`default_nettype wire

[rtl/efd_checker.sv]
// ---------------------------------------------------------------------------
// efd_checker - port-level checks of the deframer
// Output stall behavior and the shape of every emitted frame.
// ---------------------------------------------------------------------------
`default_nettype none

module efd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  logic       out_fire;
  logic [1:0] pos_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Position of the next emitted byte in its frame, saturating at two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (out_fire) begin
      if (out_last_i) begin
        pos_q <= 2'd0;
      end else if (pos_q != 2'd2) begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("frame output changed while stalled");

  // Every frame opens with version zero
  a_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (pos_q == 2'd0) |-> (out_byte_i == 8'd0))
    else $error("frame does not start with version zero");

  // Length byte of an emitted frame is above two
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (pos_q == 2'd1) |-> (out_byte_i > 8'd2))
    else $error("emitted frame has a short length byte");

  // No frame ends within its first two bytes
  a_no_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && ((pos_q == 2'd0) || (pos_q == 2'd1)) |-> !out_last_i)
    else $error("emitted frame shorter than three bytes");

endmodule

bind escaped_frame_deframer_top efd_checker u_efd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_byte_i  (frame_o.frame_byte),
  .out_last_i  (frame_o.frame_last)
);

`default_nettype wire

[dv/escaped_frame_deframer_top_tb.sv]
// ---------------------------------------------------------------------------
// escaped_frame_deframer_top_tb - self-checking bench for the deframer
// Drives byte-stuffed frames on rx_i with random gaps, random frame content
// and a share of broken frames. A scoreboard decodes the same bytes and
// checks every frame_o beat in order. The register settings change between
// phases, including the code and length extremes, and one phase stalls
// frame_o long enough to back up rx_i.
// ---------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer_top_tb;
  import efd_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 7;
  localparam int SETTLE_CYC  = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;

  // Decodes the received byte stream and keeps the frame beats still owed
  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } frame_beat_t;

    logic [7:0]  esc_code;
    logic [7:0]  start_code;
    logic [7:0]  stop_code;
    logic [6:0]  min_len;
    logic [6:0]  max_len;

    bit          esc_pending;
    bit          in_frame;
    logic [7:0]  len_byte;
    logic [6:0]  count;
    logic [7:0]  sum;
    logic [7:0]  store [MAX_FRAME];

    frame_beat_t beats_q [$];
    int          errors;
    int          beats_checked;
    int          frames_owed;

    function new();
      esc_code   = ESCAPE_RST;
      start_code = START_RST;
      stop_code  = STOP_RST;
      min_len    = MIN_LEN_RST;
      max_len    = MAX_LEN_RST;
      errors     = 0;
      beats_checked = 0;
      frames_owed   = 0;
      abort_frame();
    endfunction

    function void write_reg(reg_idx_e idx, logic [7:0] val);
      case (idx)
        REG_ESCAPE:  esc_code   = val;
        REG_START:   start_code = val;
        REG_STOP:    stop_code  = val;
        REG_MIN_LEN: min_len    = val[6:0];
        REG_MAX_LEN: max_len    = val[6:0];
        default: ;
      endcase
    endfunction

    function void abort_frame();
      esc_pending = 1'b0;
      in_frame    = 1'b0;
      len_byte    = '0;
      count       = '0;
      sum         = '0;
    endfunction

    // One payload byte into the open frame, with the running checks
    function void push_byte(logic [7:0] b);
      int unsigned limit;
      if (!in_frame) return;
      if (count == 0 && b != VERSION_0) begin
        abort_frame();
        return;
      end
      if (count == 1) begin
        len_byte = b;
        if (len_byte < {1'b0, min_len}) begin
          abort_frame();
          return;
        end
      end
      if (int'(count) < MAX_FRAME) store[count] = b;
      sum   = sum + b;
      count = count + 7'd1;
      limit = (int'(max_len) > MAX_FRAME) ? MAX_FRAME : max_len;
      if (count > limit) begin
        abort_frame();
        return;
      end
      if (len_byte != 0 && {1'b0, count} > len_byte) abort_frame();
    endfunction

    // Called for each accepted rx request
    function void note_rx(logic [7:0] b);
      frame_beat_t beat;
      if (esc_pending) begin
        esc_pending = 1'b0;
        // start wins over stop, stop over a literal escape
        if (b == start_code) begin
          abort_frame();
          in_frame = 1'b1;
        end else if (b == stop_code) begin
          if (in_frame && count > 2 && int'(count) <= MAX_FRAME &&
              store[1] == {1'b0, count} && sum == 0) begin
            for (int i = 0; i < int'(count); i++) begin
              beat.data = store[i];
              beat.last = (i == int'(count) - 1);
              beats_q = {beats_q, beat};
            end
            frames_owed++;
          end
          abort_frame();
        end else if (b == esc_code) begin
          push_byte(b);
        end else begin
          abort_frame();
        end
      end else if (b == esc_code) begin
        esc_pending = 1'b1;
      end else begin
        push_byte(b);
      end
    endfunction

    // Called for each accepted frame_o request
    function void check_result(logic [7:0] data, logic last);
      frame_beat_t exp_beat;
      if (beats_q.size() == 0) begin
        $error("unexpected frame beat: frame_byte=%02h frame_last=%0b", data, last);
        errors++;
        return;
      end
      exp_beat = beats_q.pop_front();
      beats_checked++;
      if (data !== exp_beat.data) begin
        $error("frame_byte mismatch: expected %02h, actual %02h", exp_beat.data, data);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("frame_last mismatch: expected %0b, actual %0b", exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  efd_rx_if    rx_if ();
  efd_cfg_if   cfg_if ();
  efd_frame_if frame_if ();

  escaped_frame_deframer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .cfg_i   (cfg_if),
    .frame_o (frame_if)
  );

  frame_scoreboard sb = new();

  bit idle_on;
  int hold_request;
  int rx_count;
  int cfg_count;

  // Hand-built opening stream under the reset codes: stop while closed,
  // minimal frame, frame with a literal escape and 00/FF bytes, bad escape
  logic [7:0] directed_bytes [25] = '{
    8'h1B, 8'h50,
    8'h1B, 8'h53, 8'h00, 8'h03, 8'hFD, 8'h1B, 8'h50,
    8'h1B, 8'h53, 8'h00, 8'h05, 8'h1B, 8'h1B, 8'hFF, 8'hE1, 8'h1B, 8'h50,
    8'h1B, 8'h53, 8'h00, 8'h03, 8'h1B, 8'h01
  };

  reg_idx_e reg_order [5] = '{REG_ESCAPE, REG_START, REG_STOP, REG_MIN_LEN, REG_MAX_LEN};

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Output side: random back-pressure, long hold on request, beat checks
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_if.valid && frame_if.ready)
        sb.check_result(frame_if.frame_byte, frame_if.frame_last);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        frame_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        frame_if.ready <= (stall_left == 0);
      end
    end
  end

  // One rx request, after an optional gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_rx(b);
    rx_count++;
  endtask

  // Register writes back to back, valid held across them
  task automatic apply_cfg(input logic [7:0] esc, input logic [7:0] start,
                           input logic [7:0] stop, input logic [6:0] min_l,
                           input logic [6:0] max_l);
    logic [7:0] vals [5];
    vals = '{esc, start, stop, {1'b0, min_l}, {1'b0, max_l}};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= reg_order[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_reg(reg_order[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
    cfg_count++;
  endtask

  // Wait for every owed beat, then let the pipeline drain
  task automatic idle_wait();
    rx_if.valid <= 1'b0;
    while (sb.beats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // One stuffed frame built for the current settings, sometimes broken
  task automatic send_frame(output int sent);
    logic [7:0] fr [$];
    logic [7:0] lenb;
    logic [7:0] acc;
    logic [7:0] b;
    int         eff_max, lo, hi, n, m, kind, cut;
    sent    = 0;
    eff_max = (int'(sb.max_len) > MAX_FRAME) ? MAX_FRAME : sb.max_len;
    lo      = (int'(sb.min_len) > 3) ? sb.min_len : 3;
    hi      = eff_max;
    if (lo > hi) begin
      lo = 3;
      hi = 12;
    end
    if ($urandom_range(0, 99) < 85 && hi > lo + 9) hi = lo + 9;
    n    = $urandom_range(hi, lo);
    kind = $urandom_range(0, 99);
    // kinds: <70 clean, then bad version, bad sum, length off by one,
    // length zero, bad escape, restart, missing stop, overlong
    m    = (kind >= 97) ? n + $urandom_range(1, 3) : n;
    lenb = 8'(n);
    if (kind >= 80 && kind < 85) lenb = $urandom_range(0, 1) ? lenb + 8'd1 : lenb - 8'd1;
    if (kind >= 85 && kind < 88) lenb = 8'd0;
    b  = (kind >= 70 && kind < 75) ? 8'($urandom_range(1, 255)) : VERSION_0;
    fr = {fr, b};
    fr = {fr, lenb};
    acc = fr[0] + fr[1];
    for (int i = 2; i < m - 1; i++) begin
      case ($urandom_range(0, 9))
        0:       b = sb.esc_code;
        1:       b = sb.start_code;
        2:       b = sb.stop_code;
        default: b = 8'($urandom);
      endcase
      fr  = {fr, b};
      acc = acc + b;
    end
    b  = 8'd0 - acc;
    fr = {fr, b};
    if (kind >= 75 && kind < 80) fr[m-1] = fr[m-1] ^ 8'(1 << $urandom_range(0, 7));
    cut = $urandom_range(1, m - 1);

    send_byte(sb.esc_code);
    send_byte(sb.start_code);
    sent += 2;
    for (int i = 0; i < m; i++) begin
      if (i == cut && kind >= 88 && kind < 91) begin
        do b = 8'($urandom);
        while (b == sb.start_code || b == sb.stop_code || b == sb.esc_code);
        send_byte(sb.esc_code);
        send_byte(b);
        sent += 2;
      end
      if (i == cut && kind >= 91 && kind < 94) begin
        send_byte(sb.esc_code);
        send_byte(sb.start_code);
        sent += 2;
      end
      if (fr[i] == sb.esc_code) begin
        send_byte(sb.esc_code);
        sent++;
      end
      send_byte(fr[i]);
      sent++;
    end
    if (!(kind >= 94 && kind < 97)) begin
      send_byte(sb.esc_code);
      send_byte(sb.stop_code);
      sent += 2;
    end
  endtask

  // Random frames with some line noise in between, then drain
  task automatic run_frames(input int budget);
    int done;
    int sent;
    done = 0;
    while (done < budget) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      send_frame(sent);
      done += sent;
    end
    idle_wait();
  endtask

  // Main sequence
  initial begin
    rst_ni         <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= REG_ESCAPE;
    cfg_if.data    <= '0;
    idle_on        = 1'b1;
    hold_request   = 0;
    rx_count       = 0;
    cfg_count      = 0;
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: directed stream, then random frames
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    idle_wait();
    run_frames(40);

    // Escape is zero, so every version byte gets stuffed; no length floor,
    // max length above the frame capacity
    apply_cfg(8'h00, 8'hFF, 8'h01, 7'd0, 7'd127);
    run_frames(40);

    // Only full-size frames pass, no idling on either side
    idle_on = 1'b0;
    apply_cfg(8'hFF, 8'h00, 8'h80, 7'd64, 7'd64);
    run_frames(70);
    idle_on = 1'b1;

    // Escape equal to start: an escaped escape restarts the frame
    apply_cfg(8'h55, 8'h55, 8'hAA, 7'd3, 7'd10);
    run_frames(40);

    // Escape equal to stop: an escaped escape closes the frame
    apply_cfg(8'h10, 8'h20, 8'h10, 7'd5, 7'd20);
    run_frames(40);

    // Start equal to stop and max length zero: nothing can pass
    apply_cfg(8'h7D, 8'h7E, 8'h7E, 7'd3, 7'd0);
    run_frames(20);

    // Length floor out of reach and max length one
    apply_cfg(ESCAPE_RST, START_RST, STOP_RST, 7'd127, 7'd1);
    run_frames(20);

    // Reset codes again while frame_o is held off long enough to fill the banks
    apply_cfg(ESCAPE_RST, START_RST, STOP_RST, MIN_LEN_RST, MAX_LEN_RST);
    idle_on      = 1'b0;
    hold_request = LONG_HOLD;
    run_frames(60);
    idle_on = 1'b1;
    run_frames(30);

    $display("Run covered %0d rx bytes under %0d register settings after reset",
             rx_count, cfg_count + 1);
    $display("Checked %0d frame beats from %0d accepted frames, %0d errors",
             sb.beats_checked, sb.frames_owed, sb.errors);
    if (sb.errors == 0 && sb.beats_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/efd_pkg.sv
rtl/efd_if.sv
rtl/efd_ram.sv
rtl/efd_front.sv
rtl/efd_queue.sv
rtl/efd_back.sv
rtl/escaped_frame_deframer_top.sv
rtl/efd_checker.sv
dv/escaped_frame_deframer_top_tb.sv
